FILE: hw/rtl/bffa_pkg.sv
package bffa_pkg;

    // Bitmap geometry
    localparam int MAP_WORDS  = 32;
    localparam int WORD_BITS  = 32;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 6;

    // Most words a 10-bit index can name
    localparam int INDEX_WORD_LIMIT = 32;
    localparam int ACTIVE_LIMIT =
        (MAP_WORDS < INDEX_WORD_LIMIT) ? MAP_WORDS : INDEX_WORD_LIMIT;

    localparam logic [CNT_W-1:0] WORDS_RESET = CNT_W'(32);

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/bitmap_first_free_allocator_top.sv
// First-free bitmap allocator. The block holds a bitmap of 32-bit words in
// which a one marks a free resource; after reset every bit is free. An
// allocate request (s_mode = 0) returns the lowest-numbered free bit among
// the active words, clears it and reports status 0, or status 1 with index 0
// when no active bit is free. A free request (s_mode = 1) sets bit
// s_bit_index and echoes it with status 0, or leaves the map alone and
// reports status 2 when the index lies in a word outside the active range.
// The active range is words 0 .. words_in_use-1, written through cfg_wr_en /
// cfg_wr_data; the user must write it only while no request is in flight,
// which the block itself does not enforce (reset value 32; values above 32
// act as 32, zero makes every word inactive). A request moves through the
// sequencer states in order: the idle state in which it is taken, the scan
// state in which a shared 32-bit priority encoder picks the word from a
// per-word nonempty summary and the word is read from the bitmap RAM, the
// modify state in which the same encoder picks the bit inside the read word
// and the word is written back, and the done state that moves the result
// into the output register and raises m_valid. Full and bad-index requests
// skip the modify state. s_ready is high only while the sequencer is idle,
// so no new request is taken until the last one has left the done state; a
// result that finds the output register still occupied holds the sequencer
// until m_ready frees it. The output register lets the next request be
// taken while a result still waits for m_ready. No clearing pass is needed
// after reset: per-word valid bits make an unwritten word read as all free.
module bitmap_first_free_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [bffa_pkg::CNT_W-1:0]     cfg_wr_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [bffa_pkg::IDX_W-1:0]     s_bit_index,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bffa_pkg::IDX_W-1:0]     m_granted_index,
    output logic [1:0]                     m_status
);
    import bffa_pkg::*;

    // Sequencer and request registers
    state_t                 state_reg, state_next;
    logic                   mode_reg, mode_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WORD_AW-1:0]     word_addr_reg, word_addr_next;

    // Result waiting for the output slot
    logic [IDX_W-1:0]       res_index_reg, res_index_next;
    logic [1:0]             res_status_reg, res_status_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]       out_index_reg, out_index_next;
    logic [1:0]             out_status_reg, out_status_next;

    // Configuration and per-word bookkeeping
    logic [CNT_W-1:0]       words_reg;
    logic [MAP_WORDS-1:0]   nonempty_reg, nonempty_next;
    logic [MAP_WORDS-1:0]   word_valid_reg;

    // Bitmap RAM with registered read
    logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0]   rd_word_reg;
    logic                   rd_valid_reg;
    logic                   mem_rd_en;
    logic [WORD_AW-1:0]     mem_rd_addr;
    logic                   mem_we;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [WORD_BITS-1:0]   rd_word_eff;

    // Active range
    logic [CNT_W-1:0]       active_cnt;
    logic [MAP_WORDS-1:0]   active_mask;

    // Shared priority encoder
    logic [WORD_BITS-1:0]   enc_in;
    logic [BIT_AW-1:0]      enc_idx;
    logic                   enc_any;

    logic                   out_free;
    logic [WORD_BITS-1:0]   bit_mask;

    // Cap the word count at what the map and the index can hold
    always_comb begin
        if (words_reg > CNT_W'(ACTIVE_LIMIT)) begin
            active_cnt = CNT_W'(ACTIVE_LIMIT);
        end else begin
            active_cnt = words_reg;
        end
    end

    always_comb begin
        for (int w = 0; w < MAP_WORDS; w++) begin
            active_mask[w] = (CNT_W'(w) < active_cnt);
        end
    end

    // Unwritten words read as all free
    assign rd_word_eff = rd_valid_reg ? rd_word_reg : {WORD_BITS{1'b1}};

    // Encoder source: word summary while scanning, the read word while modifying
    always_comb begin
        if (state_reg == ST_SCAN) begin
            enc_in = WORD_BITS'(nonempty_reg & active_mask);
        end else begin
            enc_in = rd_word_eff;
        end
    end

    // Lowest set bit; scan from the top so the lowest one wins
    always_comb begin
        enc_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (enc_in[b]) begin
                enc_idx = BIT_AW'(b);
            end
        end
        enc_any = |enc_in;
    end

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (mode_reg == MODE_ALLOC) begin
                    state_next = enc_any ? ST_MODIFY : ST_DONE;
                end else if (CNT_W'(idx_reg[IDX_W-1:BIT_AW]) >= active_cnt) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        word_addr_next  = word_addr_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        nonempty_next   = nonempty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = word_addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = rd_word_eff;
        bit_mask        = '0;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mode_next = s_mode;
                idx_next  = s_bit_index;
            end
            ST_SCAN: begin
                if (mode_reg == MODE_ALLOC) begin
                    // Pick the first nonempty active word
                    res_index_next  = '0;
                    res_status_next = STATUS_FULL;
                    if (enc_any) begin
                        word_addr_next = WORD_AW'(enc_idx);
                        mem_rd_addr    = WORD_AW'(enc_idx);
                        mem_rd_en      = 1'b1;
                    end
                end else begin
                    // Free: echo the index, drop it if outside the active words
                    res_index_next  = idx_reg;
                    res_status_next = STATUS_BAD_INDEX;
                    word_addr_next  = WORD_AW'(idx_reg[IDX_W-1:BIT_AW]);
                    mem_rd_addr     = WORD_AW'(idx_reg[IDX_W-1:BIT_AW]);
                    if (CNT_W'(idx_reg[IDX_W-1:BIT_AW]) < active_cnt) begin
                        mem_rd_en = 1'b1;
                    end
                end
            end
            ST_MODIFY: begin
                mem_we          = 1'b1;
                res_status_next = STATUS_OK;
                if (mode_reg == MODE_ALLOC) begin
                    bit_mask       = WORD_BITS'(1) << enc_idx;
                    mem_wdata      = rd_word_eff & ~bit_mask;
                    nonempty_next[word_addr_reg] = |(rd_word_eff & ~bit_mask);
                    res_index_next = IDX_W'({word_addr_reg, enc_idx});
                end else begin
                    bit_mask       = WORD_BITS'(1) << idx_reg[BIT_AW-1:0];
                    mem_wdata      = rd_word_eff | bit_mask;
                    nonempty_next[word_addr_reg] = 1'b1;
                    res_index_next = idx_reg;
                end
            end
            ST_DONE: begin
                // Hold the result until the output slot frees up
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_index_next  = res_index_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            words_reg      <= WORDS_RESET;
            nonempty_reg   <= {MAP_WORDS{1'b1}};
            word_valid_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            nonempty_reg <= nonempty_next;
            if (cfg_wr_en) begin
                words_reg <= cfg_wr_data;
            end
            if (mem_we) begin
                word_valid_reg[word_addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        word_addr_reg  <= word_addr_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    // Bitmap RAM
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[word_addr_reg] <= mem_wdata;
        end
        if (mem_rd_en) begin
            rd_word_reg  <= map_mem[mem_rd_addr];
            rd_valid_reg <= word_valid_reg[mem_rd_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = out_index_reg;
    assign m_status        = out_status_reg;

endmodule

FILE: test/bitmap_first_free_allocator_top_tb.sv
`timescale 1ns / 100ps

module bitmap_first_free_allocator_top_tb;
    import bffa_pkg::*;

    // One expected result: the granted (or echoed) index and its status.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [1:0]       status;
    } grant_t;

    // Shadow copy of the bitmap and the active word count. Every accepted
    // request is folded into the map at once and its grant is queued; grants
    // leave the block in request order.
    class allocator_scoreboard;
        logic [WORD_BITS-1:0] free_map [MAP_WORDS];
        logic [CNT_W-1:0]     words_in_use;
        grant_t               pending_grants [$];
        int                   mismatches;

        function new();
            for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '1;
            words_in_use = WORDS_RESET;
            mismatches = 0;
        endfunction

        function void set_words(logic [CNT_W-1:0] value);
            words_in_use = value;
        endfunction

        function void note_request(logic mode, logic [IDX_W-1:0] idx);
            grant_t      g;
            int unsigned n;
            int unsigned w;
            bit          found;
            n = words_in_use;
            if (n > ACTIVE_LIMIT) n = ACTIVE_LIMIT;
            found = 1'b0;
            g.index = '0;
            g.status = STATUS_FULL;
            if (mode == MODE_ALLOC) begin
                for (int unsigned wi = 0; wi < n; wi++) begin
                    for (int unsigned b = 0; b < WORD_BITS; b++) begin
                        if (!found && free_map[wi][b]) begin
                            found = 1'b1;
                            free_map[wi][b] = 1'b0;
                            g.index = IDX_W'(wi * WORD_BITS + b);
                            g.status = STATUS_OK;
                        end
                    end
                end
            end else begin
                g.index = idx;
                w = idx >> BIT_AW;
                if (w >= n) begin
                    g.status = STATUS_BAD_INDEX;
                end else begin
                    free_map[w][idx[BIT_AW-1:0]] = 1'b1;
                    g.status = STATUS_OK;
                end
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [IDX_W-1:0] index, logic [1:0] status);
            grant_t g;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d status %0d", index, status);
            end else begin
                g = pending_grants.pop_front();
                if (g.index !== index || g.status !== status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d, got %0d/%0d (index/status)",
                                 g.index, g.status, index, status);
                end
            end
        endfunction

        function int outstanding();
            return pending_grants.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_mode;
    logic [IDX_W-1:0] s_bit_index;
    logic             m_valid;
    logic             m_ready;
    logic [IDX_W-1:0] m_granted_index;
    logic [1:0]       m_status;

    allocator_scoreboard sb;

    bitmap_first_free_allocator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_bit_index     (s_bit_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_status        (m_status)
    );

    // 20 ns clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: the stall style changes during the run. Styles are always
    // ready, coin flip, mostly stalled, and a fixed repeating duty pattern.
    initial begin
        int unsigned ready_cnt;
        int unsigned style;
        ready_cnt = 0;
        style = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_cnt % 50 == 0) style = $urandom_range(0, 3);
            case (style)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= (ready_cnt % 7) < 3;
                end
            endcase
            ready_cnt++;
        end
    end

    // Check every result the moment it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_grant(m_granted_index, m_status);
    end

    // Present one request at the falling edge and hold it until it is taken.
    // Valid stays high on return so that a burst can go on back to back.
    task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_bit_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(mode, idx);
    endtask

    // Drop valid, wait for every outstanding grant, then let the pipeline settle.
    task automatic drain_grants();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Write the word count while the block is idle.
    task automatic write_words(input logic [CNT_W-1:0] value);
        drain_grants();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_words(value);
    endtask

    // One random phase: bursts of requests with random gaps. Frees mostly
    // hit the active words; the rest land anywhere and may be out of range.
    task automatic run_phase(input logic [CNT_W-1:0] words, input int count,
                             input int alloc_pct);
        int               burst_left;
        int               gap;
        int unsigned      n;
        logic             mode;
        logic [IDX_W-1:0] idx;
        write_words(words);
        n = words;
        if (n > ACTIVE_LIMIT) n = ACTIVE_LIMIT;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 12);
                if (gap != 0) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
                // Now and then hold off until every grant is back.
                if ($urandom_range(0, 39) == 0) drain_grants();
                burst_left = $urandom_range(1, 16);
            end
            idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
            if ($urandom_range(0, 99) < alloc_pct) begin
                mode = MODE_ALLOC;
            end else begin
                mode = MODE_FREE;
                if (n != 0 && $urandom_range(0, 99) < 85)
                    idx = IDX_W'($urandom_range(0, n - 1) * WORD_BITS
                                 + $urandom_range(0, WORD_BITS - 1));
            end
            send_request(mode, idx);
            burst_left--;
        end
    endtask

    initial begin
        logic [CNT_W-1:0] phase_words [14];
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_mode = MODE_ALLOC;
        s_bit_index = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed: reset count of 32 words.
        send_request(MODE_ALLOC, '1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, 10'd555);
        send_request(MODE_FREE, 10'd1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd1023);   // already free
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_FREE, 10'd0);      // already free
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd512);

        // One active word: frees past it are ignored.
        write_words(6'd1);
        send_request(MODE_FREE, 10'd32);
        send_request(MODE_FREE, 10'd1023);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd31);

        // No active word: allocate reports full, free a bad index.
        write_words(6'd0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_FREE, 10'd1023);

        // Count above the limit acts as 32 words.
        write_words(6'd63);
        send_request(MODE_ALLOC, 10'd682);
        send_request(MODE_FREE, 10'd1023);
        send_request(MODE_FREE, 10'd341);

        // Random phases; small counts fill up and sit near full.
        phase_words = '{6'd1, 6'd2, 6'd63, 6'd0, 6'd32, 6'd3, 6'd33, 6'd1,
                        6'd0, 6'd2, 6'd0, 6'd4, 6'd1, 6'd32};
        phase_words[8] = CNT_W'($urandom_range(1, 32));
        phase_words[10] = CNT_W'($urandom_range(0, 63));
        foreach (phase_words[p]) begin
            run_phase(phase_words[p], 110, (phase_words[p] <= 4) ? 60 : 75);
        end

        // Wait out the last grants, then watch for strays.
        drain_grants();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
